[design/tpsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared types and constants for the TGA pixel stream decoder.
// ----------------------------------------------------------------------------
package tpsd_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  localparam int CFG_W       = 13;
  localparam int DIM_W       = 13;
  localparam int IDX_W       = 24;
  localparam int CNT_W       = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DIM_W-1:0] MIN_WIDTH  = 13'd4;
  localparam logic [DIM_W-1:0] MIN_HEIGHT = 13'd1;

  localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd4;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd1;
  localparam logic [2:0]  RST_PIXEL_BYTES  = 3'd4;
  localparam logic        RST_RLE_MODE     = 1'b1;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_PIXEL_BYTES,
    REG_RUN_LENGTH_MODE
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASE,
    ST_SEG
  } back_state_t;

  typedef struct packed {
    logic four;
    logic rle;
  } fmt_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } geom_t;

  typedef struct packed {
    logic             soi;
    logic [CNT_W-1:0] count;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[design/tga_pixel_stream_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_top
// TGA true-color pixel data decoder, raw or run-length, to row segments.
// ----------------------------------------------------------------------------
// The intake takes one data word per cycle while its 4-entry command queue
// has room; each completed pixel and each start of image becomes one queued
// command. The segment writer takes a command, emits the row segments it
// causes (a run of up to 128 pixels over narrow rows gives up to 33), and
// does the row base multiply in a separate state at start of image and
// at every row change. Uncompressed pixels (3 or 4 words each) therefore
// sustain one word per cycle while the output is not stalled; long runs that
// cross rows hold the intake once the queue fills. Results wait in an output
// register and do not block intake of the next word.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_top
  import tpsd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             start_of_image,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] pixel_index,
  output logic [CNT_W-1:0] pixel_count,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       alpha,
  output logic             last_in_step,
  output logic             image_done
);

  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [2:0]  pixel_bytes;
  logic        run_length_mode;

  fmt_t   fmt;
  geom_t  geom;
  qstat_t qstat;
  cmd_t   push_cmd, head;
  logic   push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= RST_IMAGE_WIDTH;
      image_height    <= RST_IMAGE_HEIGHT;
      pixel_bytes     <= RST_PIXEL_BYTES;
      run_length_mode <= RST_RLE_MODE;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_IMAGE_WIDTH:     image_width     <= cfg_data[12:0];
        REG_IMAGE_HEIGHT:    image_height    <= cfg_data[12:0];
        REG_PIXEL_BYTES:     pixel_bytes     <= cfg_data[2:0];
        REG_RUN_LENGTH_MODE: run_length_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    fmt.four = (pixel_bytes >= 3'd4);
    fmt.rle  = run_length_mode;
    if (image_width < MIN_WIDTH) begin
      geom.width = MIN_WIDTH;
    end else if (32'(image_width) > MAX_WIDTH) begin
      geom.width = DIM_W'(MAX_WIDTH);
    end else begin
      geom.width = image_width;
    end
    if (image_height < MIN_HEIGHT) begin
      geom.height = MIN_HEIGHT;
    end else if (32'(image_height) > MAX_HEIGHT) begin
      geom.height = DIM_W'(MAX_HEIGHT);
    end else begin
      geom.height = image_height;
    end
  end

  tpsd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .start_of_image (start_of_image),
    .fmt            (fmt),
    .qstat          (qstat),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  tpsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  tpsd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .geom         (geom),
    .q_valid      (!qstat.empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_index  (pixel_index),
    .pixel_count  (pixel_count),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .last_in_step (last_in_step),
    .image_done   (image_done)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_done |-> last_in_step)
    else $error("image_done on a segment that is not last in step");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_count != '0) && (pixel_count <= 8'd128))
    else $error("segment count out of range");

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty together");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("command pushed into full queue");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

[design/tpsd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsd_front
// Byte intake: packet header parsing and pixel assembly into commands.
// ----------------------------------------------------------------------------
module tpsd_front
  import tpsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       start_of_image,
  input  fmt_t       fmt,
  input  qstat_t     qstat,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [1:0]       phase, phase_next;
  logic [31:0]      held, held_next;
  logic [CNT_W-1:0] remaining, remaining_next;
  logic             is_run, is_run_next;
  logic             await_hdr, await_hdr_next;

  logic [1:0]       p0;
  logic [31:0]      h0, held_or;
  logic [CNT_W-1:0] r0, r_dec;
  logic             run0, a0;
  logic [2:0]       phase_inc, need;
  logic             accept;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    p0   = start_of_image ? 2'd0 : phase;
    h0   = start_of_image ? 32'd0 : held;
    r0   = start_of_image ? '0 : remaining;
    run0 = start_of_image ? 1'b0 : is_run;
    a0   = start_of_image ? 1'b1 : await_hdr;

    held_or   = h0 | (32'(data_byte) << {p0, 3'b000});
    phase_inc = {1'b0, p0} + 3'd1;
    need      = fmt.four ? 3'd4 : 3'd3;
    r_dec     = (r0 != '0) ? r0 - 1'b1 : '0;

    phase_next     = phase;
    held_next      = held;
    remaining_next = remaining;
    is_run_next    = is_run;
    await_hdr_next = await_hdr;
    push           = 1'b0;
    push_cmd       = '0;

    if (accept) begin
      phase_next     = p0;
      held_next      = h0;
      remaining_next = r0;
      is_run_next    = run0;
      await_hdr_next = a0;
      if (fmt.rle && a0) begin
        is_run_next    = data_byte[7];
        remaining_next = {1'b0, data_byte[6:0]} + 1'b1;
        await_hdr_next = 1'b0;
        phase_next     = 2'd0;
        held_next      = 32'd0;
      end else if (phase_inc < need) begin
        phase_next = phase_inc[1:0];
        held_next  = held_or;
      end else begin
        phase_next     = 2'd0;
        held_next      = 32'd0;
        push           = 1'b1;
        push_cmd.red   = held_or[23:16];
        push_cmd.green = held_or[15:8];
        push_cmd.blue  = held_or[7:0];
        push_cmd.alpha = fmt.four ? held_or[31:24] : 8'd0;
        if (!fmt.rle) begin
          push_cmd.count = 8'd1;
        end else if (run0) begin
          push_cmd.count = r0;
          remaining_next = '0;
          await_hdr_next = 1'b1;
        end else begin
          push_cmd.count = 8'd1;
          remaining_next = r_dec;
          if (r_dec == '0) begin
            await_hdr_next = 1'b1;
          end
        end
      end
      // start word never completes a pixel
      if (start_of_image) begin
        push         = 1'b1;
        push_cmd     = '0;
        push_cmd.soi = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 2'd0;
      held      <= 32'd0;
      remaining <= '0;
      is_run    <= 1'b0;
      await_hdr <= 1'b1;
    end else begin
      phase     <= phase_next;
      held      <= held_next;
      remaining <= remaining_next;
      is_run    <= is_run_next;
      await_hdr <= await_hdr_next;
    end
  end

endmodule

[design/tpsd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsd_queue
// Small command queue between the byte intake and the segment writer.
// ----------------------------------------------------------------------------
module tpsd_queue
  import tpsd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  cmd_t   push_cmd,
  input  logic   pop,
  output cmd_t   head,
  output qstat_t qstat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_QW-1:0] fill;

  assign head        = mem[rd_ptr];
  assign qstat.full  = (fill == CNT_QW'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[design/tpsd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsd_back
// Segment writer: places each pixel command into bottom-up rows before it takes
// the next, one row segment at a time, recomputing the row base at each row change.
// ----------------------------------------------------------------------------
module tpsd_back
  import tpsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  geom_t            geom,
  input  logic             q_valid,
  input  cmd_t             head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] pixel_index,
  output logic [CNT_W-1:0] pixel_count,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       alpha,
  output logic             last_in_step,
  output logic             image_done
);

  back_state_t state, state_next;

  logic [DIM_W-1:0] row, row_next;
  logic [DIM_W-1:0] col, col_next;
  logic [IDX_W-1:0] base, base_next;
  logic             finished, finished_next;
  logic [CNT_W-1:0] rem, rem_next;
  logic [7:0]       c_red, c_green, c_blue, c_alpha;
  logic             load_color;

  logic [DIM_W-1:0]   room, col_sum, flip_row;
  logic [CNT_W-1:0]   n;
  logic [DIM_W:0]     row_inc;
  logic [2*DIM_W-1:0] prod;
  logic               wrap, finishing, can_emit, emit;

  assign can_emit = !out_valid || out_ready;

  always_comb begin
    room      = (col < geom.width) ? geom.width - col : '0;
    n         = ({5'b0, rem} <= room) ? rem : room[CNT_W-1:0];
    col_sum   = col + {5'b0, n};
    wrap      = (col_sum >= geom.width);
    row_inc   = {1'b0, row} + 1'b1;
    finishing = wrap && (row_inc >= {1'b0, geom.height});
    flip_row  = (row < geom.height) ? geom.height - 1'b1 - row : '0;
    prod      = flip_row * geom.width;
  end

  always_comb begin
    state_next    = state;
    row_next      = row;
    col_next      = col;
    base_next     = base;
    finished_next = finished;
    rem_next      = rem;
    load_color    = 1'b0;
    pop           = 1'b0;
    emit          = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (head.soi) begin
            row_next      = '0;
            col_next      = '0;
            finished_next = 1'b0;
            rem_next      = '0;
            state_next    = ST_BASE;
          end else if (!finished && head.count != '0) begin
            rem_next   = head.count;
            load_color = 1'b1;
            state_next = ST_SEG;
          end
        end
      end
      ST_BASE: begin
        base_next  = prod[IDX_W-1:0];
        state_next = (rem != '0) ? ST_SEG : ST_IDLE;
      end
      ST_SEG: begin
        if (n == '0 || can_emit) begin
          emit     = (n != '0);
          rem_next = rem - n;
          col_next = wrap ? '0 : col_sum;
          if (wrap) begin
            row_next = row_inc[DIM_W-1:0];
            if (finishing) begin
              finished_next = 1'b1;
              rem_next      = '0;
              state_next    = ST_IDLE;
            end else begin
              state_next = ST_BASE;
            end
          end else begin
            state_next = (rem == n) ? ST_IDLE : ST_SEG;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row       <= '0;
      col       <= '0;
      base      <= '0;
      finished  <= 1'b0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      row      <= row_next;
      col      <= col_next;
      base     <= base_next;
      finished <= finished_next;
      rem      <= rem_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_color) begin
      c_red   <= head.red;
      c_green <= head.green;
      c_blue  <= head.blue;
      c_alpha <= head.alpha;
    end
    if (emit) begin
      pixel_index  <= base + {11'b0, col};
      pixel_count  <= n;
      red          <= c_red;
      green        <= c_green;
      blue         <= c_blue;
      alpha        <= c_alpha;
      last_in_step <= (rem == n) || finishing;
      image_done   <= finishing;
    end
  end

endmodule

[sim/tga_pixel_stream_decoder_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_top_tb
// Self-checking bench for the TGA pixel stream decoder.
// ----------------------------------------------------------------------------
// A queue-fed driver sends pixel-data words with random gaps, and a monitor
// takes row segments with random stalls. Each accepted word runs through a
// local decoder model that predicts the segments it causes. Directed images
// cover the format extremes, long runs over narrow rows, clamped registers,
// dropped pixels past the last row and a width change mid-image. Random
// images follow with random geometry, format and packet content.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_top_tb;
  import tpsd_pkg::*;

  localparam int unsigned MAX_W = DEF_MAX_WIDTH;
  localparam int unsigned MAX_H = DEF_MAX_HEIGHT;

  typedef struct packed {
    logic [7:0] data;
    logic       soi;
  } word_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             last;
    logic             done;
  } segment_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       data_byte = '0;
  logic             start_of_image = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [IDX_W-1:0] pixel_index;
  logic [CNT_W-1:0] pixel_count;
  logic [7:0]       red, green, blue, alpha;
  logic             last_in_step;
  logic             image_done;

  word_t    word_q[$];
  segment_t segment_q[$];
  segment_t step_segs[0:32];
  int       step_n;
  int       mismatches = 0;
  int       live_words = 0;
  int       send_gap = 0;
  int       send_calm = 0;
  int       take_stall = 0;
  int       take_calm = 0;

  // decoder model state
  logic [12:0] cfg_width = 13'd4;
  logic [12:0] cfg_height = 13'd1;
  logic [2:0]  cfg_bpp = 3'd4;
  logic        cfg_rle = 1'b1;
  int unsigned row_n, col_n, row_base, phase_n, pkt_left;
  logic        pkt_run, want_header, img_full;
  logic [31:0] px_word;

  tga_pixel_stream_decoder_top DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .start_of_image (start_of_image),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel_index    (pixel_index),
    .pixel_count    (pixel_count),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .alpha          (alpha),
    .last_in_step   (last_in_step),
    .image_done     (image_done)
  );

  always #5 clk = ~clk;

  function automatic int unsigned used_width();
    int unsigned w;
    w = 32'(cfg_width);
    if (w < 4) w = 4;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned used_height();
    int unsigned h;
    h = 32'(cfg_height);
    if (h < 1) h = 1;
    if (h > MAX_H) h = MAX_H;
    return h;
  endfunction

  function automatic int unsigned used_bytes();
    return (cfg_bpp < 4) ? 3 : 4;
  endfunction

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left = calm_left - 1;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm_left = int'($urandom_range(10, 40));
    return int'($urandom_range(0, 12));
  endfunction

  task automatic load_row_base();
    int unsigned h, r;
    longint unsigned prod;
    h = used_height();
    r = (row_n < h) ? h - 1 - row_n : 0;
    prod = longint'(r) * longint'(used_width());
    row_base = 32'(prod & 64'hffffff);
  endtask

  task automatic clear_image();
    row_n = 0;
    col_n = 0;
    row_base = 0;
    phase_n = 0;
    pkt_left = 0;
    pkt_run = 1'b0;
    want_header = 1'b1;
    px_word = '0;
    img_full = 1'b0;
  endtask

  task automatic put_pixels(input int unsigned count);
    int unsigned w, room, n;
    segment_t s;
    while (count > 0 && !img_full) begin
      w = used_width();
      room = (col_n < w) ? w - col_n : 0;
      n = (count < room) ? count : room;
      if (n > 0 && step_n < 33) begin
        s.idx   = IDX_W'(row_base + col_n);
        s.cnt   = CNT_W'(n);
        s.red   = px_word[23:16];
        s.green = px_word[15:8];
        s.blue  = px_word[7:0];
        s.alpha = (used_bytes() == 4) ? px_word[31:24] : 8'd0;
        s.last  = 1'b0;
        s.done  = 1'b0;
        step_segs[step_n] = s;
        step_n++;
      end
      col_n += n;
      count -= n;
      if (col_n >= w) begin
        col_n = 0;
        row_n++;
        if (row_n >= used_height()) begin
          img_full = 1'b1;
          if (n > 0 && step_n > 0) step_segs[step_n-1].done = 1'b1;
        end else begin
          load_row_base();
        end
      end
    end
  endtask

  task automatic decode_word(input logic [7:0] b, input logic soi);
    int i;
    step_n = 0;
    live_words++;
    if (soi) begin
      clear_image();
      load_row_base();
    end
    if (!img_full) begin
      if (cfg_rle && want_header) begin
        pkt_run = b[7];
        pkt_left = 32'(b[6:0]) + 1;
        want_header = 1'b0;
        phase_n = 0;
        px_word = '0;
      end else begin
        px_word = px_word | ({24'd0, b} << (8 * (phase_n & 3)));
        if (phase_n + 1 < used_bytes()) begin
          phase_n = (phase_n + 1) & 3;
        end else begin
          phase_n = 0;
          if (!cfg_rle) begin
            put_pixels(1);
          end else if (pkt_run) begin
            put_pixels(pkt_left);
            pkt_left = 0;
            want_header = 1'b1;
          end else begin
            put_pixels(1);
            pkt_left = (pkt_left > 0) ? pkt_left - 1 : 0;
            if (pkt_left == 0) want_header = 1'b1;
          end
          px_word = '0;
          if (step_n > 0) step_segs[step_n-1].last = 1'b1;
          for (i = 0; i < step_n; i++) segment_q.push_back(step_segs[i]);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) decode_word(data_byte, start_of_image);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (word_q.size() > 0) begin
        w = word_q.pop_front();
        data_byte <= w.data;
        start_of_image <= w.soi;
        in_valid <= 1'b1;
        send_gap = draw_wait(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    segment_t got, exp_seg;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.idx   = pixel_index;
        got.cnt   = pixel_count;
        got.red   = red;
        got.green = green;
        got.blue  = blue;
        got.alpha = alpha;
        got.last  = last_in_step;
        got.done  = image_done;
        if (segment_q.size() == 0) begin
          report_mismatch($sformatf("unexpected segment idx=%0d cnt=%0d", got.idx, got.cnt));
        end else begin
          exp_seg = segment_q.pop_front();
          if (got !== exp_seg)
            report_mismatch($sformatf(
              "idx %0d/%0d cnt %0d/%0d rgba %h%h%h%h/%h%h%h%h last %b/%b done %b/%b",
              got.idx, exp_seg.idx, got.cnt, exp_seg.cnt,
              got.red, got.green, got.blue, got.alpha,
              exp_seg.red, exp_seg.green, exp_seg.blue, exp_seg.alpha,
              got.last, exp_seg.last, got.done, exp_seg.done));
        end
        take_stall = draw_wait(take_calm);
      end
      if (take_stall > 0) begin
        take_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_word(input logic [7:0] b, input logic soi);
    word_t w;
    w.data = b;
    w.soi = soi;
    word_q.push_back(w);
  endtask

  task automatic push_pixel(input logic [31:0] px);
    int j;
    for (j = 0; j < used_bytes(); j++) push_word(px[8*j +: 8], 1'b0);
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [12:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:     cfg_width = v;
      REG_IMAGE_HEIGHT:    cfg_height = v;
      REG_PIXEL_BYTES:     cfg_bpp = v[2:0];
      REG_RUN_LENGTH_MODE: cfg_rle = v[0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (word_q.size() > 0 || in_valid || segment_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_image();
    int unsigned budget, sent, eb, len, npx, k, j;
    logic run, soi_next;
    logic [12:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 13'd0;
          1: v = 13'd3;
          2: v = 13'd4096;
          default: v = 13'd8191;
        endcase
      end
      1: v = 13'($urandom_range(11, 600));
      default: v = 13'($urandom_range(4, 10));
    endcase
    set_reg(REG_IMAGE_WIDTH, v);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0: v = 13'd0;
          1: v = 13'd4096;
          default: v = 13'd8191;
        endcase
      end
      1: v = 13'($urandom_range(6, 40));
      default: v = 13'($urandom_range(1, 5));
    endcase
    set_reg(REG_IMAGE_HEIGHT, v);
    set_reg(REG_PIXEL_BYTES, 13'($urandom_range(0, 7)));
    set_reg(REG_RUN_LENGTH_MODE, ($urandom_range(0, 9) < 6) ? 13'd1 : 13'd0);
    eb = used_bytes();
    soi_next = ($urandom_range(0, 5) != 0);
    budget = $urandom_range(20, 45);
    sent = 0;
    while (sent < budget) begin
      if (cfg_rle) begin
        run = 1'($urandom_range(0, 1));
        if (run && $urandom_range(0, 3) == 0) len = $urandom_range(0, 127);
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(0, 20);
        else len = $urandom_range(0, 5);
        push_word({run, len[6:0]}, soi_next);
        soi_next = 1'b0;
        sent++;
        npx = run ? 1 : len + 1;
      end else begin
        npx = 1;
      end
      if ($urandom_range(0, 9) == 0) begin
        // cut the packet short and restart the image
        npx = $urandom_range(0, npx);
        for (j = 0; j < $urandom_range(1, eb - 1); j++) begin
          push_word(8'($urandom_range(0, 255)), soi_next);
          soi_next = 1'b0;
          sent++;
        end
        soi_next = 1'b1;
      end
      for (k = 0; k < npx; k++) begin
        for (j = 0; j < eb; j++) begin
          push_word(8'($urandom_range(0, 255)), soi_next);
          soi_next = 1'b0;
          sent++;
        end
      end
      if ($urandom_range(0, 15) == 0) soi_next = 1'b1;
    end
    settle();
  endtask

  initial begin
    #20_000_000;
    $display("[tga_pixel_stream_decoder_top] ERROR");
    $finish;
  end

  initial begin
    clear_image();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset registers, no start of image: run of 4 fills the only row
    push_word(8'h83, 1'b0);
    push_pixel(32'hff00ff00);
    push_word(8'h55, 1'b0);
    settle();

    // 128-pixel run starting at column 1 over 4-wide rows
    set_reg(REG_IMAGE_WIDTH, 13'd4);
    set_reg(REG_IMAGE_HEIGHT, 13'd40);
    set_reg(REG_PIXEL_BYTES, 13'd4);
    set_reg(REG_RUN_LENGTH_MODE, 13'd1);
    push_word(8'h00, 1'b1);
    push_pixel(32'hffffffff);
    push_word(8'hff, 1'b0);
    push_pixel(32'hfe018000);
    settle();

    // clamped geometry, 3-byte uncompressed
    set_reg(REG_IMAGE_WIDTH, 13'd0);
    set_reg(REG_IMAGE_HEIGHT, 13'd8191);
    set_reg(REG_PIXEL_BYTES, 13'd0);
    set_reg(REG_RUN_LENGTH_MODE, 13'd0);
    push_word(8'h12, 1'b1);
    push_word(8'h34, 1'b0);
    push_word(8'h56, 1'b0);
    settle();

    // width shrinks below the current column mid-image
    set_reg(REG_IMAGE_WIDTH, 13'd8);
    set_reg(REG_IMAGE_HEIGHT, 13'd3);
    set_reg(REG_PIXEL_BYTES, 13'd7);
    set_reg(REG_RUN_LENGTH_MODE, 13'd1);
    push_word(8'h85, 1'b1);
    push_pixel(32'h80402010);
    settle();
    set_reg(REG_IMAGE_WIDTH, 13'd4);
    push_word(8'h80, 1'b0);
    push_pixel(32'h01020304);
    settle();

    while (live_words < 280) random_image();

    if (mismatches == 0) $display("[tga_pixel_stream_decoder_top] OK");
    else $display("[tga_pixel_stream_decoder_top] ERROR");
    $finish;
  end

endmodule
